>>> rtl/homogeneous_point_transform_unit_defines.svh
// Assertion macros for the homogeneous point transform unit.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_UNIT_DEFINES_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define HPTU_ASSERT_IMP(lbl, lhs, rhs, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define HPTU_ASSERT_NEXT(lbl, lhs, rhs, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

>>> rtl/hptu_pkg.sv
// Shared types and constants of the homogeneous point transform unit.
package hptu_pkg;
   typedef logic signed [31:0] coord_type;
   typedef logic [1:0]         status_type;
   typedef logic signed [65:0] row_type;

   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_SAT      = 2'd1;
   localparam status_type STATUS_ZERO_DEN = 2'd2;

   localparam coord_type CoordMax = 32'sh7FFF_FFFF;
   localparam coord_type CoordMin = 32'sh8000_0000;

   localparam int PairCount     = 8;
   localparam int CsrIndexWidth = 4;
   localparam int RowCount      = 4;
   localparam int CoordLanes    = 3;
   localparam int RowStages     = 3;
   localparam int DivSteps      = 32;
   localparam int DivStages     = DivSteps + 2;
   localparam int PipeStages    = RowStages + DivStages + 1;

   localparam logic [63:0] PAIR_RESET [PairCount] = '{
      64'd65536, 64'd0, 64'd281474976710656, 64'd0,
      64'd0, 64'd65536, 64'd0, 64'd281474976710656
   };

   typedef struct packed {
      logic [31:0] quot;
      logic        neg;
      logic        ovf;
      logic        dzero;
   } lane_result_type;
endpackage

>>> rtl/homogeneous_point_transform_unit.sv
// Top level of the homogeneous point transform unit: registers, lanes, pipeline control.
//
// Accepts one Q16.16 point per cycle while req_ready is high and returns its transformed,
// perspective-divided point after multiply and sum in four row lanes, magnitude and
// overflow check, restoring divide (one quotient bit per stage, one divider lane per
// coordinate) and one merge stage. A skid register captures a finished result that
// the consumer does not take, and the pipeline stalls while that register is full.
// The coefficient registers reset to the values of PAIR_RESET in hptu_pkg.
`include "homogeneous_point_transform_unit_defines.svh"

module homogeneous_point_transform_unit (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  hptu_pkg::coord_type                       req_point_x,
   input  hptu_pkg::coord_type                       req_point_y,
   input  hptu_pkg::coord_type                       req_point_z,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output hptu_pkg::coord_type                       rsp_out_x,
   output hptu_pkg::coord_type                       rsp_out_y,
   output hptu_pkg::coord_type                       rsp_out_z,
   output hptu_pkg::status_type                      rsp_status,
   input  logic                                      csr_wr_en,
   input  logic [hptu_pkg::CsrIndexWidth-1:0]        csr_index,
   input  logic [63:0]                               csr_wdata
);
   import hptu_pkg::*;

   localparam int Last = PipeStages - 1;

   logic [63:0]           coef_pair_ff [PairCount];
   coord_type             coef [16];
   logic [PipeStages-1:0] valid_ff;
   logic                  en;
   row_type               rows [RowCount];
   lane_result_type       lane_res [CoordLanes];
   coord_type             end_x, end_y, end_z;
   status_type            end_status;
   logic                  skid_valid_ff;
   coord_type             skid_x_ff, skid_y_ff, skid_z_ff;
   status_type            skid_status_ff;
   logic                  rsp_zero, rsp_clamped;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PairCount; i++) coef_pair_ff[i] <= PAIR_RESET[i];
      end else if (csr_wr_en && (csr_index < CsrIndexWidth'(PairCount))) begin
         coef_pair_ff[csr_index[2:0]] <= csr_wdata;
      end
   end

   for (genvar k = 0; k < 16; k++) begin : g_coef
      assign coef[k] = (k % 2 == 1) ? coord_type'(coef_pair_ff[k/2][63:32])
                                    : coord_type'(coef_pair_ff[k/2][31:0]);
   end

   assign en        = !skid_valid_ff;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[PipeStages-2:0], req_valid};
      end
   end

   for (genvar r = 0; r < RowCount; r++) begin : g_row
      hptu_row_lane u_row (
         .clock (clock),
         .en    (en),
         .x     (req_point_x),
         .y     (req_point_y),
         .z     (req_point_z),
         .c0    (coef[r]),
         .c1    (coef[r+4]),
         .c2    (coef[r+8]),
         .c3    (coef[r+12]),
         .row   (rows[r])
      );
   end

   for (genvar r = 0; r < CoordLanes; r++) begin : g_div
      hptu_div_lane u_div (
         .clock  (clock),
         .en     (en),
         .num    (rows[r]),
         .den    (rows[RowCount-1]),
         .result (lane_res[r])
      );
   end

   hptu_merge u_merge (
      .clock    (clock),
      .en       (en),
      .lane_res (lane_res),
      .out_x    (end_x),
      .out_y    (end_y),
      .out_z    (end_z),
      .status   (end_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ready) skid_valid_ff <= 1'b0;
      end else if (valid_ff[Last] && !rsp_ready) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff && valid_ff[Last] && !rsp_ready) begin
         skid_x_ff      <= end_x;
         skid_y_ff      <= end_y;
         skid_z_ff      <= end_z;
         skid_status_ff <= end_status;
      end
   end

   assign rsp_valid  = skid_valid_ff || valid_ff[Last];
   assign rsp_out_x  = skid_valid_ff ? skid_x_ff : end_x;
   assign rsp_out_y  = skid_valid_ff ? skid_y_ff : end_y;
   assign rsp_out_z  = skid_valid_ff ? skid_z_ff : end_z;
   assign rsp_status = skid_valid_ff ? skid_status_ff : end_status;

   assign rsp_zero    = (rsp_out_x == '0) && (rsp_out_y == '0) && (rsp_out_z == '0);
   assign rsp_clamped = (rsp_out_x == CoordMax) || (rsp_out_x == CoordMin)
                     || (rsp_out_y == CoordMax) || (rsp_out_y == CoordMin)
                     || (rsp_out_z == CoordMax) || (rsp_out_z == CoordMin);

   `HPTU_ASSERT_IMP(a_zero_den_clears, rsp_valid && rsp_status == STATUS_ZERO_DEN, rsp_zero, "zero denominator with nonzero coordinate")
   `HPTU_ASSERT_IMP(a_sat_extreme, rsp_valid && rsp_status == STATUS_SAT, rsp_clamped, "saturation without a clamped coordinate")
   `HPTU_ASSERT_IMP(a_ready_when_empty, !rsp_valid, req_ready, "stalled with no pending result")
   `HPTU_ASSERT_NEXT(a_transfer_enters, req_valid && req_ready, valid_ff[0], "accepted transfer lost at entry")
endmodule

>>> rtl/hptu_row_lane.sv
// One matrix row: three products plus translation, summed at Q32.32 over three stages.
module hptu_row_lane (
   input  logic                clock,
   input  logic                en,
   input  hptu_pkg::coord_type x,
   input  hptu_pkg::coord_type y,
   input  hptu_pkg::coord_type z,
   input  hptu_pkg::coord_type c0,
   input  hptu_pkg::coord_type c1,
   input  hptu_pkg::coord_type c2,
   input  hptu_pkg::coord_type c3,
   output hptu_pkg::row_type   row
);
   import hptu_pkg::*;

   logic signed [63:0] p0_ff, p1_ff, p2_ff, pc_ff;
   logic signed [64:0] s0_ff, s1_ff;
   row_type            row_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff  <= 64'(c0) * 64'(x);
         p1_ff  <= 64'(c1) * 64'(y);
         p2_ff  <= 64'(c2) * 64'(z);
         pc_ff  <= {{16{c3[31]}}, c3, 16'd0};
         s0_ff  <= 65'(p0_ff) + 65'(p1_ff);
         s1_ff  <= 65'(p2_ff) + 65'(pc_ff);
         row_ff <= 66'(s0_ff) + 66'(s1_ff);
      end
   end

   assign row = row_ff;
endmodule

>>> rtl/hptu_div_lane.sv
// One coordinate divider: magnitudes, overflow check and a 32-stage restoring divide.
module hptu_div_lane (
   input  logic                      clock,
   input  logic                      en,
   input  hptu_pkg::row_type         num,
   input  hptu_pkg::row_type         den,
   output hptu_pkg::lane_result_type result
);
   import hptu_pkg::*;

   logic [63:0] nmag_ff, dmag_ff;
   logic        nneg_ff, dneg_ff, dz_ff;

   logic [63:0] rem_ff  [DivSteps+1];
   logic [31:0] quot_ff [DivSteps+1];
   logic [15:0] low_ff  [DivSteps+1];
   logic [63:0] dv_ff   [DivSteps+1];
   logic        neg_ff  [DivSteps+1];
   logic        ovf_ff  [DivSteps+1];
   logic        dzs_ff  [DivSteps+1];

   always_ff @(posedge clock) begin
      if (en) begin
         nmag_ff <= num[65] ? (~num[63:0] + 64'd1) : num[63:0];
         nneg_ff <= num[65];
         dmag_ff <= den[65] ? (~den[63:0] + 64'd1) : den[63:0];
         dneg_ff <= den[65];
         dz_ff   <= (den == '0);

         rem_ff[0]  <= {16'd0, nmag_ff[63:16]};
         quot_ff[0] <= '0;
         low_ff[0]  <= nmag_ff[15:0];
         dv_ff[0]   <= dmag_ff;
         neg_ff[0]  <= nneg_ff ^ dneg_ff;
         ovf_ff[0]  <= {16'd0, nmag_ff} >= {dmag_ff, 16'd0};
         dzs_ff[0]  <= dz_ff;
      end
   end

   for (genvar s = 1; s <= DivSteps; s++) begin : g_step
      logic [64:0] trial;
      logic        take;
      assign trial = {rem_ff[s-1], low_ff[s-1][15]};
      assign take  = trial >= {1'b0, dv_ff[s-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= take ? 64'(trial - {1'b0, dv_ff[s-1]}) : trial[63:0];
            quot_ff[s] <= {quot_ff[s-1][30:0], take};
            low_ff[s]  <= {low_ff[s-1][14:0], 1'b0};
            dv_ff[s]   <= dv_ff[s-1];
            neg_ff[s]  <= neg_ff[s-1];
            ovf_ff[s]  <= ovf_ff[s-1];
            dzs_ff[s]  <= dzs_ff[s-1];
         end
      end
   end

   assign result.quot  = quot_ff[DivSteps];
   assign result.neg   = neg_ff[DivSteps];
   assign result.ovf   = ovf_ff[DivSteps];
   assign result.dzero = dzs_ff[DivSteps];
endmodule

>>> rtl/hptu_merge.sv
// Merge stage: sign, saturation and status from the three divider lanes.
module hptu_merge (
   input  logic                      clock,
   input  logic                      en,
   input  hptu_pkg::lane_result_type lane_res [3],
   output hptu_pkg::coord_type       out_x,
   output hptu_pkg::coord_type       out_y,
   output hptu_pkg::coord_type       out_z,
   output hptu_pkg::status_type      status
);
   import hptu_pkg::*;

   coord_type  val [CoordLanes];
   logic [2:0] sat;
   status_type status_in;
   coord_type  x_ff, y_ff, z_ff;
   status_type status_ff;

   always_comb begin
      for (int i = 0; i < CoordLanes; i++) begin
         if (lane_res[i].neg) begin
            sat[i] = lane_res[i].ovf || (lane_res[i].quot > 32'h8000_0000);
            val[i] = sat[i] ? CoordMin : coord_type'(~lane_res[i].quot + 32'd1);
         end else begin
            sat[i] = lane_res[i].ovf || lane_res[i].quot[31];
            val[i] = sat[i] ? CoordMax : coord_type'(lane_res[i].quot);
         end
      end
      priority if (lane_res[0].dzero) status_in = STATUS_ZERO_DEN;
      else if (|sat)                  status_in = STATUS_SAT;
      else                            status_in = STATUS_OK;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff      <= lane_res[0].dzero ? '0 : val[0];
         y_ff      <= lane_res[0].dzero ? '0 : val[1];
         z_ff      <= lane_res[0].dzero ? '0 : val[2];
         status_ff <= status_in;
      end
   end

   assign out_x  = x_ff;
   assign out_y  = y_ff;
   assign out_z  = z_ff;
   assign status = status_ff;
endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the homogeneous point transform unit.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import hptu_pkg::*;

   typedef struct packed {
      coord_type  x;
      coord_type  y;
      coord_type  z;
      status_type st;
   } point_result_type;

   typedef struct {
      int               setup;
      coord_type        x;
      coord_type        y;
      coord_type        z;
      bit               typed;
      point_result_type res;
   } stim_row_type;

   localparam int SETUP_IDENTITY = 0;
   localparam int SETUP_ZERO_DEN = 1;
   localparam int SETUP_TINY_W   = 2;
   localparam int SETUP_MIXED    = 3;
   localparam int RandPhases     = 12;
   localparam int PhaseItems     = 120;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   coord_type                req_point_x = '0;
   coord_type                req_point_y = '0;
   coord_type                req_point_z = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   coord_type                rsp_out_x;
   coord_type                rsp_out_y;
   coord_type                rsp_out_z;
   status_type               rsp_status;
   logic                     csr_wr_en = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [63:0]              csr_wdata = '0;

   logic [63:0]      coef_shadow [PairCount];
   point_result_type expected_points [$];
   int               error_count = 0;
   int               checked_count = 0;
   int               sent_count = 0;
   int               zero_den_count = 0;
   int               sat_count = 0;
   bit               calm = 1'b0;

   homogeneous_point_transform_unit i_dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("[homogeneous_point_transform_unit] ERROR");
      $finish;
   end

   function automatic logic signed [127:0] coef_at(int k);
      logic [63:0] p;
      p = coef_shadow[k >> 1];
      return (k & 1) ? 128'($signed(p[63:32])) : 128'($signed(p[31:0]));
   endfunction

   function automatic point_result_type transform_point(coord_type x, coord_type y,
                                                        coord_type z);
      logic signed [127:0] rows [RowCount];
      logic [127:0]        dmag;
      logic [127:0]        nmag;
      logic [127:0]        q;
      logic [31:0]         lane [CoordLanes];
      bit                  dneg;
      bit                  nneg;
      bit                  sat;
      point_result_type    res;
      sat = 1'b0;
      for (int r = 0; r < RowCount; r++) begin
         rows[r] = coef_at(r) * 128'(x) + coef_at(r + 4) * 128'(y)
                 + coef_at(r + 8) * 128'(z) + coef_at(r + 12) * 128'sd65536;
      end
      if (rows[3] == 0) begin
         res = '{x: '0, y: '0, z: '0, st: STATUS_ZERO_DEN};
         return res;
      end
      dneg = rows[3] < 0;
      dmag = dneg ? -rows[3] : rows[3];
      for (int r = 0; r < CoordLanes; r++) begin
         nneg = rows[r] < 0;
         nmag = nneg ? -rows[r] : rows[r];
         q = (nmag << 16) / dmag;
         if (nneg != dneg) begin
            if (q > 128'h8000_0000) begin
               sat = 1'b1;
               lane[r] = CoordMin;
            end else begin
               lane[r] = 32'(-q);
            end
         end else if (q > 128'h7FFF_FFFF) begin
            sat = 1'b1;
            lane[r] = CoordMax;
         end else begin
            lane[r] = q[31:0];
         end
      end
      res = '{x: lane[0], y: lane[1], z: lane[2], st: sat ? STATUS_SAT : STATUS_OK};
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
   endtask

   task automatic wait_drained();
      while (expected_points.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic load_matrix(logic [63:0] pairs [PairCount]);
      for (int k = 0; k < PairCount; k++) begin
         csr_wr_en <= 1'b1;
         csr_index <= CsrIndexWidth'(k);
         csr_wdata <= pairs[k];
         coef_shadow[k] = pairs[k];
         @(posedge clock);
      end
      csr_index <= CsrIndexWidth'($urandom_range(15, PairCount));
      csr_wdata <= {$urandom, $urandom};
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [31:0] pick_coef();
      case ($urandom_range(7))
         0: return 32'd0;
         1: return 32'd65536;
         2: return -32'sd65536;
         3: return CoordMax;
         4: return CoordMin;
         5: return 32'($signed($urandom_range(262143)) - 131072);
         default: return $urandom;
      endcase
   endfunction

   function automatic coord_type pick_coord();
      case ($urandom_range(9))
         0: return CoordMax;
         1: return CoordMin;
         2: return '0;
         3, 4, 5: return 32'($signed($urandom_range(2097151)) - 1048576);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_point(coord_type x, coord_type y, coord_type z, bit typed,
                             point_result_type res);
      if (!calm && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      do @(posedge clock); while (!req_ready);
      expected_points.push_back(typed ? res : transform_point(x, y, z));
      sent_count++;
   endtask

   always @(posedge clock) begin
      rsp_ready <= !reset && (calm || $urandom_range(99) >= 30);
   end

   always @(posedge clock) begin
      point_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_out_x, '0);
         end else begin
            want = expected_points.pop_front();
            checked_count++;
            if (rsp_out_x !== want.x) report_mismatch("out_x", rsp_out_x, want.x);
            if (rsp_out_y !== want.y) report_mismatch("out_y", rsp_out_y, want.y);
            if (rsp_out_z !== want.z) report_mismatch("out_z", rsp_out_z, want.z);
            if (rsp_status !== want.st) report_mismatch("status", rsp_status, want.st);
            if (want.st == STATUS_ZERO_DEN) zero_den_count++;
            if (want.st == STATUS_SAT) sat_count++;
         end
      end
   end

   initial begin
      stim_row_type     rows [$];
      logic [63:0]      pairs [PairCount];
      point_result_type none;
      int               setup;
      int               calm_start;
      none = '0;
      for (int k = 0; k < PairCount; k++) coef_shadow[k] = PAIR_RESET[k];
      rows = '{
         '{SETUP_IDENTITY, 32'sd0, 32'sd0, 32'sd0, 1, '{0, 0, 0, STATUS_OK}},
         '{SETUP_IDENTITY, CoordMax, CoordMin, 32'sd1,
           1, '{CoordMax, CoordMin, 32'sd1, STATUS_OK}},
         '{SETUP_IDENTITY, CoordMin, CoordMax, -32'sd1,
           1, '{CoordMin, CoordMax, -32'sd1, STATUS_OK}},
         '{SETUP_IDENTITY, 32'sh0001_8000, -32'sh0002_4000, CoordMax,
           1, '{32'sh0001_8000, -32'sh0002_4000, CoordMax, STATUS_OK}},
         '{SETUP_ZERO_DEN, 32'sd5, -32'sd7, CoordMax, 1, '{0, 0, 0, STATUS_ZERO_DEN}},
         '{SETUP_ZERO_DEN, CoordMin, CoordMin, CoordMin, 1, '{0, 0, 0, STATUS_ZERO_DEN}},
         '{SETUP_TINY_W, 32'sd1, 32'sd0, -32'sd1,
           1, '{32'sd65536, 32'sd0, -32'sd65536, STATUS_OK}},
         '{SETUP_TINY_W, 32'sh8000, -32'sh8000, 32'sd0,
           1, '{CoordMax, CoordMin, 32'sd0, STATUS_SAT}},
         '{SETUP_TINY_W, CoordMax, CoordMin, 32'sd2,
           1, '{CoordMax, CoordMin, 32'sd131072, STATUS_SAT}},
         '{SETUP_TINY_W, -32'sh8001, 32'sh7FFF, 32'sd0,
           1, '{CoordMin, 32'sh7FFF_0000, 32'sd0, STATUS_SAT}},
         '{SETUP_MIXED, 32'sh0003_0000, -32'sh0001_0000, 32'sh0000_8000, 0, none},
         '{SETUP_MIXED, CoordMax, CoordMax, CoordMax, 0, none},
         '{SETUP_MIXED, CoordMin, CoordMin, CoordMin, 0, none},
         '{SETUP_MIXED, 32'sd0, 32'sd0, 32'sd0, 0, none},
         '{SETUP_MIXED, -32'sd12345, 32'sd987654, -32'sd55, 0, none}
      };
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      setup = SETUP_IDENTITY;
      foreach (rows[i]) begin
         if (rows[i].setup != setup) begin
            setup = rows[i].setup;
            req_valid <= 1'b0;
            wait_drained();
            for (int k = 0; k < PairCount; k++) pairs[k] = PAIR_RESET[k];
            if (setup == SETUP_ZERO_DEN) pairs[7] = '0;
            if (setup == SETUP_TINY_W) pairs[7] = {32'd1, 32'd0};
            if (setup == SETUP_MIXED) begin
               pairs = '{64'h0000_8000_0002_0000, 64'h0000_4000_FFFF_0000,
                         64'hFFFF_8000_0001_0000, 64'h0000_2000_0000_0000,
                         64'h0001_0000_0000_4000, 64'hFFFF_C000_0003_0000,
                         64'h0002_0000_FFFE_0000, 64'h0001_0000_0000_1000};
            end
            load_matrix(pairs);
         end
         send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].res);
      end
      calm_start = $urandom_range(RandPhases - 3, 2);
      for (int ph = 0; ph < RandPhases; ph++) begin
         req_valid <= 1'b0;
         wait_drained();
         calm = (ph == calm_start) || (ph == calm_start + 1);
         for (int k = 0; k < PairCount; k++) begin
            case (ph)
               0: pairs[k] = {CoordMax, CoordMax};
               1: pairs[k] = {CoordMin, CoordMin};
               default: pairs[k] = {pick_coef(), pick_coef()};
            endcase
         end
         if (ph % 4 == 3) pairs[1][63:32] = '0;
         if (ph % 4 == 3) pairs[3][63:32] = '0;
         if (ph % 4 == 3) pairs[5][63:32] = '0;
         if (ph % 4 == 3) pairs[7][63:32] = (ph == 3) ? 32'd0 : 32'd65536;
         load_matrix(pairs);
         for (int n = 0; n < PhaseItems; n++) begin
            send_point(pick_coord(), pick_coord(), pick_coord(), 1'b0, none);
         end
      end
      req_valid <= 1'b0;
      calm = 1'b0;
      wait_drained();
      repeat (PipeStages + 8) @(posedge clock);
      $display("%0d points sent over %0d matrix settings, %0d results checked",
               sent_count, RandPhases + 4, checked_count);
      $display("%0d zero-denominator and %0d saturated results seen",
               zero_den_count, sat_count);
      if (error_count == 0 && expected_points.size() == 0) begin
         $display("[homogeneous_point_transform_unit] OK");
      end else begin
         $display("[homogeneous_point_transform_unit] ERROR");
      end
      $finish;
   end
endmodule
